// ----- src/pwq_pkg.sv -----
// ----------------------------------------------------------------------------
// pwq_pkg: shared definitions for the priority wait queue
// Sizes, operation and status codes, cell command codes, and the types
// that pass between the controller and the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pwq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried by an input beat.
  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_CHANGE  = 3'd2;
  localparam logic [2:0] OP_TAKE    = 3'd3;
  localparam logic [2:0] OP_BLOCK   = 3'd4;
  localparam logic [2:0] OP_UNBLOCK = 3'd5;

  // Status codes carried by a result beat.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BLOCKED    = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [2:0] ST_DUPLICATE  = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  // What every cell does in a cycle.
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_SHIFT  = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
    entry_t     item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/priority_wait_queue.sv -----
// ----------------------------------------------------------------------------
// priority_wait_queue: ordered wait queue of thread ids
// Keeps ids sorted by descending priority, first come first served among
// equal priorities, in a row of shifting cells driven by a small controller.
// ----------------------------------------------------------------------------
// Results: each result beat is registered from the controller state that
//   makes it; a priority change deletes, then inserts, before its beat.
//   A block drain gives one beat per cycle.
// Commands: a new command is taken only while the queue is idle, so
//   each one, block drains included, ends before the next is accepted.
// Reset: synchronous; the queue comes up empty and blocked. Cell contents
//   are not cleared, since the entry count alone decides which are live.
// The receiver cannot stall: each result beat is shown for one cycle only.
`default_nettype none

module priority_wait_queue
  import pwq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] thread_id,
  input  wire logic [7:0] priority_req,
  output logic            done,
  output logic [2:0]      status,
  output logic [7:0]      taken_id,
  output logic [7:0]      taken_priority,
  output logic [5:0]      entry_count,
  output logic            is_blocked,
  output logic            last_result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_INS   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  // Controller registers.
  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [2:0]         cmd_op;
  entry_t             cmd_item;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               blocked;
  logic               blocked_next;

  // Result decisions made this cycle, registered onto the ports.
  logic       emit;
  logic [2:0] st;
  entry_t     taken;
  logic       last;

  // Row of cells.
  cell_ctrl_t             ctrl;
  entry_t                 data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH:0]   del_chain;
  logic                   found;
  logic                   full;

  assign busy       = (state != S_IDLE);
  assign found      = |match;
  assign full       = (count == COUNT_W'(QUEUE_DEPTH));
  assign del_chain[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   keep_left;
      logic   valid_e;

      // A cell is live when its place lies below the entry count.
      assign valid_e = (COUNT_W'(i) < count);

      if (i == 0) begin : g_head
        assign left_e    = data[0];
        assign keep_left = 1'b1;
      end else begin : g_body
        assign left_e    = data[i-1];
        assign keep_left = keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = data[i];
      end else begin : g_inner
        assign right_e = data[i+1];
      end

      pwq_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .valid   (valid_e),
        .left    (left_e),
        .right   (right_e),
        .keep_in (keep_left),
        .del_in  (del_chain[i]),
        .data    (data[i]),
        .keep    (keep[i]),
        .del_out (del_chain[i+1]),
        .match   (match[i])
      );
    end
  endgenerate

  // The controller works on the latched command. An enqueue inserts in
  // one pass; a remove closes the gap at the matching cell; a priority
  // change removes in one pass and inserts at the tail of its new level
  // in the next. Take and block pull entries off the head of the row.
  always_comb begin
    ctrl.mode    = MODE_HOLD;
    ctrl.item    = cmd_item;
    emit         = 1'b0;
    st           = ST_OK;
    taken        = '0;
    last         = 1'b1;
    count_next   = count;
    blocked_next = blocked;
    state_next   = state;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        case (cmd_op)
          OP_ENQUEUE: begin
            if (blocked) begin
              st = ST_BLOCKED;
            end else if (found) begin
              st = ST_DUPLICATE;
            end else if (full) begin
              st = ST_FULL;
            end else begin
              ctrl.mode  = MODE_INSERT;
              count_next = count + COUNT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (!found) begin
              st = ST_NOT_QUEUED;
            end else begin
              ctrl.mode  = MODE_DELETE;
              count_next = count - COUNT_W'(1);
            end
          end
          OP_CHANGE: begin
            if (!found) begin
              st = ST_NOT_QUEUED;
            end else begin
              ctrl.mode  = MODE_DELETE;
              count_next = count - COUNT_W'(1);
              emit       = 1'b0;
              state_next = S_INS;
            end
          end
          OP_TAKE: begin
            if (count == '0) begin
              st = ST_EMPTY;
            end else begin
              ctrl.mode  = MODE_SHIFT;
              taken      = data[0];
              count_next = count - COUNT_W'(1);
            end
          end
          OP_BLOCK: begin
            blocked_next = 1'b1;
            if (count != '0) begin
              ctrl.mode  = MODE_SHIFT;
              taken      = data[0];
              count_next = count - COUNT_W'(1);
              last       = (count == COUNT_W'(1));
              if (count != COUNT_W'(1)) begin
                state_next = S_DRAIN;
              end
            end
          end
          OP_UNBLOCK: blocked_next = 1'b0;
          default: ;
        endcase
      end
      S_INS: begin
        ctrl.mode  = MODE_INSERT;
        count_next = count + COUNT_W'(1);
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_DRAIN: begin
        ctrl.mode  = MODE_SHIFT;
        taken      = data[0];
        count_next = count - COUNT_W'(1);
        emit       = 1'b1;
        last       = (count == COUNT_W'(1));
        if (count == COUNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      blocked <= 1'b1;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      blocked <= blocked_next;
      done    <= emit;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_op        <= opcode;
      cmd_item.id   <= thread_id[ID_BITS-1:0];
      cmd_item.prio <= priority_req[PRIO_BITS-1:0];
    end
    status         <= st;
    taken_id       <= taken.id;
    taken_priority <= taken.prio;
    entry_count    <= count_next;
    is_blocked     <= blocked_next;
    last_result    <= last;
  end

endmodule

`default_nettype wire

// ----- src/pwq_cell.sv -----
// ----------------------------------------------------------------------------
// pwq_cell: one slot of the sorted chain
// Holds one entry, compares it with the broadcast item, and takes its
// left or right neighbor's entry when the chain opens or closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module pwq_cell
  import pwq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       valid,
  input  wire entry_t     left,
  input  wire entry_t     right,
  input  wire logic       keep_in,
  input  wire logic       del_in,
  output entry_t          data,
  output logic            keep,
  output logic            del_out,
  output logic            match
);

  entry_t data_next;

  // Entries at or above the new priority stay where they are; sorting
  // makes this a prefix of the chain.
  assign keep    = valid && (data.prio >= ctrl.item.prio);
  assign match   = valid && (data.id == ctrl.item.id);
  assign del_out = del_in | match;

  always_comb begin
    data_next = data;
    case (ctrl.mode)
      MODE_INSERT: begin
        if (!keep) begin
          data_next = keep_in ? ctrl.item : left;
        end
      end
      MODE_DELETE: begin
        if (del_out) begin
          data_next = right;
        end
      end
      MODE_SHIFT: data_next = right;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ----- src/pwq_checker.sv -----
// ----------------------------------------------------------------------------
// pwq_checker: port-level checks for the priority wait queue
// Watches the command and result ports over time and flags behavior that
// the queue must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module pwq_checker
  import pwq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] opcode,
  input wire logic [7:0] thread_id,
  input wire logic [7:0] priority_req,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic [7:0] taken_id,
  input wire logic [7:0] taken_priority,
  input wire logic [5:0] entry_count,
  input wire logic       is_blocked,
  input wire logic       last_result
);

  // An accepted command keeps the queue busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("queue not busy after accepting a command");

  // The final beat of a command frees the queue; an earlier beat does not.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> (last_result == !busy))
    else $error("busy does not follow the final result beat");

  // Failed commands never hand out an entry.
  a_fail_no_take: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> taken_id == '0 && taken_priority == '0)
    else $error("entry reported on a failed command");

  // A refusal for blocking only happens while blocked, and no beat
  // reports more entries than the store holds.
  a_refuse_blocked: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != ST_BLOCKED || is_blocked) &&
             entry_count <= 6'(QUEUE_DEPTH))
    else $error("inconsistent blocked status or entry count");

  // A drain beat that is not the last keeps entries behind it.
  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    done && !last_result |-> entry_count != '0)
    else $error("drain continues with an empty queue");

endmodule

bind priority_wait_queue pwq_checker u_pwq_checker (.*);

`default_nettype wire
